// ===== src/tpdq_pkg.sv =====
// Package for the deadline timer queue: codes, record types and helpers.
// No dependencies; used by every other file of the block but tpdq_if.sv.
`timescale 1ns / 1ps

package tpdq_pkg;

    localparam int SLOT_W   = 6;               // wide enough for any slot index
    localparam int DL_W     = 32;
    localparam int NUM_SLOTS_DEF = 32;         // slot field is 5 bits wide
    localparam logic [SLOT_W-1:0] MAX_FIRE = 6'd32;

    // command modes
    localparam logic [2:0] MODE_ALLOC  = 3'd0;
    localparam logic [2:0] MODE_FREE   = 3'd1;
    localparam logic [2:0] MODE_BIND   = 3'd2;
    localparam logic [2:0] MODE_ARM    = 3'd3;
    localparam logic [2:0] MODE_CANCEL = 3'd4;
    localparam logic [2:0] MODE_TICK   = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_ALLOC = 2'd1;
    localparam logic [1:0] KIND_POST  = 2'd2;
    localparam logic [1:0] KIND_TASK  = 2'd3;

    // slot status
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    // config register indexes
    localparam logic [1:0] REG_TASK_SLOT   = 2'd0;
    localparam logic [1:0] REG_TASK_ENABLE = 2'd1;
    localparam logic [1:0] REG_SLOWDOWN    = 2'd2;

    // cell operations
    localparam logic [1:0] CELL_NOP    = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_REMOVE = 2'd2;
    localparam logic [1:0] CELL_POP    = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [DL_W-1:0]   dl;
    } entry_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [SLOT_W-1:0] key;
        logic [DL_W-1:0]   dl;
    } cell_cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        ok;
        logic [4:0]  slot_out;
        logic [7:0]  channel_out;
        logic [31:0] payload_out;
        logic        last;
    } rsp_t;

    function automatic rsp_t mk_rsp(input logic [1:0] kind, input logic ok,
                                    input logic [4:0] slot, input logic [7:0] ch,
                                    input logic [31:0] pl, input logic last);
        rsp_t r;
        r.kind        = kind;
        r.ok          = ok;
        r.slot_out    = slot;
        r.channel_out = ch;
        r.payload_out = pl;
        r.last        = last;
        return r;
    endfunction

endpackage

// ===== src/tpdq_if.sv =====
// Valid/ready channel interfaces for commands and results of the timer queue.
// No dependencies.
`timescale 1ns / 1ps

interface tpdq_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [4:0]  slot;
    logic [7:0]  channel;
    logic [31:0] payload;
    logic [31:0] delay;

    modport source (output valid, mode, slot, channel, payload, delay, input ready);
    modport sink   (input valid, mode, slot, channel, payload, delay, output ready);
endinterface

interface tpdq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        ok;
    logic [4:0]  slot_out;
    logic [7:0]  channel_out;
    logic [31:0] payload_out;
    logic        last;

    modport source (output valid, kind, ok, slot_out, channel_out, payload_out, last,
                    input ready);
    modport sink   (input valid, kind, ok, slot_out, channel_out, payload_out, last,
                    output ready);
endinterface

// ===== src/tpdq_cell.sv =====
// One cell of the sorted run queue: holds one entry and shifts with its neighbours.
// Depends on tpdq_pkg.
`timescale 1ns / 1ps

module tpdq_cell
    import tpdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  entry_t    left_ent,
    input  logic      left_ahead,
    input  entry_t    right_ent,
    input  logic      hit_in,
    output entry_t    ent,
    output logic      ahead,
    output logic      hit_out
);

    entry_t ent_reg, ent_next;

    // entry stays ahead of a new deadline only if strictly earlier
    assign ahead   = ent_reg.valid && (ent_reg.dl < cmd.dl);
    assign hit_out = hit_in || (ent_reg.valid && (ent_reg.slot == cmd.key));
    assign ent     = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (!ahead)
                begin
                    if (left_ahead)
                    begin
                        ent_next.valid = 1'b1;
                        ent_next.slot  = cmd.key;
                        ent_next.dl    = cmd.dl;
                    end
                    else
                    begin
                        ent_next = left_ent;
                    end
                end
            end
            CELL_REMOVE:
            begin
                if (hit_out)
                    ent_next = right_ent;
            end
            CELL_POP:
            begin
                ent_next = right_ent;
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_reg <= '0;
        else
            ent_reg <= ent_next;
    end

endmodule

// ===== src/timer_pool_deadline_queue_unit.sv =====
// Deadline timer pool: slot status table, payload store and a chain of queue cells.
// Depends on tpdq_pkg, tpdq_if and tpdq_cell.
`timescale 1ns / 1ps

// Usage
//   cmd : command transfers (allocate, free, bind, arm, cancel, tick). One command
//         is taken at a time; ready is high only when the block is idle and the
//         result register is empty.
//   rsp : result transfers; the final result of a command carries last.
//   cfg : plain write port for task_slot, task_slot_enable and slowdown.
// Sequencing
//   allocate, bind and unknown modes answer in the cycle after their transfer;
//   free and cancel of a running timer pass S_UNLINK; arm passes S_INSERT, after
//   S_UNLINK when re-arming. A counted tick walks the queue head: S_FIRE and S_POST
//   per posted expiry, S_FIRE per task slot expiry, then S_FIRE (head check) and
//   S_END (final result), plus an S_END step for a task request after a post.
// Reset
//   all slots free, queue empty, tick and prescale counts zero, config cleared.
//   Channel and payload store is not cleared; it is valid once bound.
// Stall
//   a stalled rsp holds its result; expiry walking pauses until the result
//   register frees, and no new command is taken meanwhile.

module timer_pool_deadline_queue_unit
    import tpdq_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    tpdq_cmd_if.sink         cmd,
    tpdq_rsp_if.source       rsp,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] NS = SLOT_W'(NUM_SLOTS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UNLINK = 3'd1;
    localparam logic [2:0] S_INSERT = 3'd2;
    localparam logic [2:0] S_FIRE   = 3'd3;
    localparam logic [2:0] S_POST   = 3'd4;
    localparam logic [2:0] S_END    = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [2:0]        mode_reg, mode_next;
    logic [SLOT_W-1:0] key_reg, key_next;
    logic              ok_reg, ok_next;
    logic [31:0]       dl_reg, dl_next;
    logic [31:0]       tick_reg, tick_next;
    logic [7:0]        pre_reg, pre_next;
    logic [4:0]        task_slot_reg;
    logic              task_en_reg;
    logic [7:0]        slowdown_reg;
    logic [1:0]        status_reg [NUM_SLOTS];
    logic [SLOT_W-1:0] fire_n_reg, fire_n_next;
    logic              ts_reg, ts_next;
    logic              held_valid_reg, held_valid_next;
    logic [SLOT_W-1:0] held_slot_reg, held_slot_next;
    logic [7:0]        held_ch_reg, held_ch_next;
    logic [31:0]       held_pl_reg, held_pl_next;
    logic [SLOT_W-1:0] post_slot_reg, post_slot_next;
    logic              out_valid_reg;
    rsp_t              out_reg;

    // channel / payload store
    logic [7:0]  ch_mem [NUM_SLOTS];
    logic [31:0] pl_mem [NUM_SLOTS];
    logic [7:0]  rd_ch_reg;
    logic [31:0] rd_pl_reg;
    logic        mem_we;

    logic        st_we;
    logic [IW-1:0] st_idx;
    logic [1:0]  st_val;

    logic        out_load;
    rsp_t        out_data;
    logic        out_free;

    cell_cmd_t   ccmd;
    entry_t      ent [NUM_SLOTS];
    logic        bef [NUM_SLOTS];
    logic        hit [NUM_SLOTS];

    logic [SLOT_W-1:0] in_slot;
    logic [IW-1:0]     in_idx;
    logic              in_range;
    logic              in_running;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic [IW-1:0]     head_idx;
    logic              head_fire;
    logic              head_task;

    // ---- cell chain ----
    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++)
        begin : gen_cell
            entry_t le, re;
            logic   lb, hi;
            if (g == 0)
            begin : gen_head
                assign le = '0;
                assign lb = 1'b1;
                assign hi = 1'b0;
            end
            else
            begin : gen_mid
                assign le = ent[g-1];
                assign lb = bef[g-1];
                assign hi = hit[g-1];
            end
            if (g == NUM_SLOTS - 1)
            begin : gen_tail
                assign re = '0;
            end
            else
            begin : gen_body
                assign re = ent[g+1];
            end
            tpdq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (ccmd),
                .left_ent    (le),
                .left_ahead  (lb),
                .right_ent   (re),
                .hit_in      (hi),
                .ent         (ent[g]),
                .ahead       (bef[g]),
                .hit_out     (hit[g])
            );
        end
    endgenerate

    // ---- decode helpers ----
    assign in_slot    = {1'b0, cmd.slot};
    assign in_idx     = in_slot[IW-1:0];
    assign in_range   = in_slot < NS;
    assign in_running = status_reg[in_idx] == ST_RUN;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (status_reg[i] == ST_FREE)
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign head_idx  = ent[0].slot[IW-1:0];
    assign head_fire = ent[0].valid && (ent[0].dl <= tick_reg) && (fire_n_reg < MAX_FIRE);
    assign head_task = task_en_reg && (ent[0].slot == {1'b0, task_slot_reg});

    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && !out_valid_reg;

    // ---- sequencer ----
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        ok_next         = ok_reg;
        dl_next         = dl_reg;
        tick_next       = tick_reg;
        pre_next        = pre_reg;
        fire_n_next     = fire_n_reg;
        ts_next         = ts_reg;
        held_valid_next = held_valid_reg;
        held_slot_next  = held_slot_reg;
        held_ch_next    = held_ch_reg;
        held_pl_next    = held_pl_reg;
        post_slot_next  = post_slot_reg;
        ccmd            = '{op: CELL_NOP, key: key_reg, dl: dl_reg};
        out_load        = 1'b0;
        out_data        = mk_rsp(KIND_ACK, 1'b0, 5'd0, 8'd0, 32'd0, 1'b1);
        st_we           = 1'b0;
        st_idx          = in_idx;
        st_val          = ST_FREE;
        mem_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid && cmd.ready)
                begin
                    mode_next = cmd.mode;
                    key_next  = in_slot;
                    ok_next   = 1'b0;
                    unique case (cmd.mode)
                        MODE_ALLOC:
                        begin
                            out_load = 1'b1;
                            out_data = mk_rsp(KIND_ALLOC, free_found, free_idx[4:0],
                                              8'd0, 32'd0, 1'b1);
                            if (free_found)
                            begin
                                st_we  = 1'b1;
                                st_idx = free_idx[IW-1:0];
                                st_val = ST_ALLOC;
                            end
                        end
                        MODE_FREE:
                        begin
                            if (in_range)
                            begin
                                st_we  = 1'b1;
                                st_val = ST_FREE;
                            end
                            if (in_range && in_running)
                                state_next = S_UNLINK;
                            else
                                out_load = 1'b1;
                        end
                        MODE_BIND:
                        begin
                            mem_we   = in_range;
                            out_load = 1'b1;
                        end
                        MODE_ARM:
                        begin
                            if (in_range)
                            begin
                                st_we      = 1'b1;
                                st_val     = ST_RUN;
                                dl_next    = tick_reg + cmd.delay;
                                state_next = in_running ? S_UNLINK : S_INSERT;
                            end
                            else
                            begin
                                out_load = 1'b1;
                            end
                        end
                        MODE_CANCEL:
                        begin
                            if (in_range && in_running)
                            begin
                                st_we      = 1'b1;
                                st_val     = ST_ALLOC;
                                ok_next    = 1'b1;
                                state_next = S_UNLINK;
                            end
                            else
                            begin
                                out_load = 1'b1;
                            end
                        end
                        MODE_TICK:
                        begin
                            if (pre_reg < slowdown_reg)
                            begin
                                pre_next = pre_reg + 8'd1;
                                out_load = 1'b1;
                            end
                            else
                            begin
                                pre_next    = '0;
                                tick_next   = tick_reg + 32'd1;
                                fire_n_next = '0;
                                ts_next     = 1'b0;
                                state_next  = S_FIRE;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_UNLINK:
            begin
                ccmd.op = CELL_REMOVE;
                if (mode_reg == MODE_ARM)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    out_load   = 1'b1;
                    out_data   = mk_rsp(KIND_ACK, ok_reg, 5'd0, 8'd0, 32'd0, 1'b1);
                    state_next = S_IDLE;
                end
            end
            S_INSERT:
            begin
                ccmd.op    = CELL_INSERT;
                out_load   = 1'b1;
                state_next = S_IDLE;
            end
            S_FIRE:
            begin
                st_idx = head_idx;
                st_val = ST_ALLOC;
                if (head_fire)
                begin
                    if (head_task)
                    begin
                        ccmd.op     = CELL_POP;
                        st_we       = 1'b1;
                        ts_next     = 1'b1;
                        fire_n_next = fire_n_reg + 1'b1;
                    end
                    else if (!held_valid_reg || out_free)
                    begin
                        // an earlier post is known not to be the final one
                        if (held_valid_reg)
                        begin
                            out_load        = 1'b1;
                            out_data        = mk_rsp(KIND_POST, 1'b0, held_slot_reg[4:0],
                                                     held_ch_reg, held_pl_reg, 1'b0);
                            held_valid_next = 1'b0;
                        end
                        ccmd.op        = CELL_POP;
                        st_we          = 1'b1;
                        fire_n_next    = fire_n_reg + 1'b1;
                        post_slot_next = ent[0].slot;
                        state_next     = S_POST;
                    end
                end
                else
                begin
                    state_next = S_END;
                end
            end
            S_POST:
            begin
                held_valid_next = 1'b1;
                held_slot_next  = post_slot_reg;
                held_ch_next    = rd_ch_reg;
                held_pl_next    = rd_pl_reg;
                state_next      = S_FIRE;
            end
            S_END:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (held_valid_reg)
                    begin
                        out_data        = mk_rsp(KIND_POST, 1'b0, held_slot_reg[4:0],
                                                 held_ch_reg, held_pl_reg, !ts_reg);
                        held_valid_next = 1'b0;
                        if (!ts_reg)
                            state_next = S_IDLE;
                    end
                    else if (ts_reg)
                    begin
                        out_data   = mk_rsp(KIND_TASK, 1'b0, task_slot_reg, 8'd0, 32'd0,
                                            1'b1);
                        ts_next    = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---- control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_reg       <= '0;
            pre_reg        <= '0;
            fire_n_reg     <= '0;
            ts_reg         <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            task_slot_reg  <= '0;
            task_en_reg    <= 1'b0;
            slowdown_reg   <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
                status_reg[i] <= ST_FREE;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            pre_reg        <= pre_next;
            fire_n_reg     <= fire_n_next;
            ts_reg         <= ts_next;
            held_valid_reg <= held_valid_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (st_we)
                status_reg[st_idx] <= st_val;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TASK_SLOT:   task_slot_reg <= cfg_data[4:0];
                    REG_TASK_ENABLE: task_en_reg   <= cfg_data[0];
                    REG_SLOWDOWN:    slowdown_reg  <= cfg_data;
                    default:         task_en_reg   <= task_en_reg;
                endcase
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        key_reg       <= key_next;
        ok_reg        <= ok_next;
        dl_reg        <= dl_next;
        held_slot_reg <= held_slot_next;
        held_ch_reg   <= held_ch_next;
        held_pl_reg   <= held_pl_next;
        post_slot_reg <= post_slot_next;
        if (out_load)
            out_reg <= out_data;
    end

    // ---- channel / payload store ----
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ch_mem[in_idx] <= cmd.channel;
            pl_mem[in_idx] <= cmd.payload;
        end
        rd_ch_reg <= ch_mem[head_idx];
        rd_pl_reg <= pl_mem[head_idx];
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = out_reg.kind;
    assign rsp.ok          = out_reg.ok;
    assign rsp.slot_out    = out_reg.slot_out;
    assign rsp.channel_out = out_reg.channel_out;
    assign rsp.payload_out = out_reg.payload_out;
    assign rsp.last        = out_reg.last;

endmodule

// ===== test/tpdq_tb_if.sv =====
// Testbench copies of nothing: the block's own interfaces live in src/tpdq_if.sv.
// This file holds the small scoreboard class used by the testbench top; depends on tpdq_pkg.
`timescale 1ns / 1ps

class tpdq_result_board;
    tpdq_pkg::rsp_t pending[$];
    int             errors;

    function void note_expected(tpdq_pkg::rsp_t r);
        pending.push_back(r);
    endfunction

    function void check_result(tpdq_pkg::rsp_t got);
        tpdq_pkg::rsp_t want;
        if (pending.size() == 0)
        begin
            errors++;
            $display("%0t unexpected result: actual %p", $time, got);
            return;
        end
        want = pending.pop_front();
        if (got !== want)
        begin
            errors++;
            $display("%0t result mismatch: expected %p actual %p", $time, want, got);
        end
    endfunction
endclass

// ===== test/timer_pool_deadline_queue_unit_tb.sv =====
// Testbench top for the deadline timer pool: drives commands, ticks and config writes,
// predicts results in place and checks them via tpdq_result_board. Depends on src files.
`timescale 1ns / 1ps

module timer_pool_deadline_queue_unit_tb;
    import tpdq_pkg::*;

    localparam int NSLOT = 32;
    localparam int LIMIT = 2000000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    tpdq_cmd_if cmd ();
    tpdq_rsp_if rsp ();

    timer_pool_deadline_queue_unit #(.NUM_SLOTS(NSLOT)) i_dut (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [1:0]  status[NSLOT];
    logic [7:0]  chan[NSLOT];
    logic [31:0] word[NSLOT];
    logic [31:0] due[NSLOT];
    bit          bound[NSLOT];
    int          order[$];
    logic [31:0] now_count;
    logic [7:0]  pre_count;
    logic [4:0]  task_no;
    logic        task_on;
    logic [7:0]  slow;

    tpdq_result_board board = new();
    int cycles;
    int posts;
    int ticks_counted;
    int rsp_gap;

    // unlink a slot from the run order if present
    function automatic void drop_slot(int s);
        foreach (order[i])
            if (order[i] == s)
            begin
                order.delete(i);
                return;
            end
    endfunction

    // new timer goes ahead of every equal-or-later deadline
    function automatic void place_slot(int s);
        int i;
        i = 0;
        while (i < order.size() && due[order[i]] < due[s])
            i++;
        order.insert(i, s);
    endfunction

    function automatic void predict(logic [2:0] m, logic [4:0] s, logic [7:0] ch,
                                    logic [31:0] pl, logic [31:0] dl);
        rsp_t r[$];
        int   n;
        bit   ts;
        bit   ok;
        int   f;
        ok = 0;
        ts = 0;
        n = 0;
        f = 0;
        if (m == MODE_TICK)
        begin
            if (pre_count < slow)
            begin
                pre_count++;
                r.push_back(mk_rsp(KIND_ACK, 1'b0, 5'd0, 8'd0, 32'd0, 1'b0));
            end
            else
            begin
                pre_count = 0;
                now_count = now_count + 1;
                ticks_counted++;
                while (n < order.size() && n < 32 && due[order[n]] <= now_count)
                begin
                    f = order[n];
                    status[f] = ST_ALLOC;
                    if (task_on && f == task_no)
                        ts = 1;
                    else
                        r.push_back(mk_rsp(KIND_POST, 1'b0, f[4:0], chan[f], word[f], 1'b0));
                    n++;
                end
                repeat (n) void'(order.pop_front());
                if (ts)
                    r.push_back(mk_rsp(KIND_TASK, 1'b0, task_no, 8'd0, 32'd0, 1'b0));
                if (r.size() == 0)
                    r.push_back(mk_rsp(KIND_ACK, 1'b0, 5'd0, 8'd0, 32'd0, 1'b0));
            end
        end
        else if (m == MODE_ALLOC)
        begin
            f = -1;
            for (int i = 0; i < NSLOT; i++)
                if (f < 0 && status[i] == ST_FREE)
                    f = i;
            if (f >= 0)
            begin
                status[f] = ST_ALLOC;
                r.push_back(mk_rsp(KIND_ALLOC, 1'b1, f[4:0], 8'd0, 32'd0, 1'b0));
            end
            else
                r.push_back(mk_rsp(KIND_ALLOC, 1'b0, 5'd0, 8'd0, 32'd0, 1'b0));
        end
        else
        begin
            if (m == MODE_FREE)
            begin
                if (status[s] == ST_RUN)
                    drop_slot(s);
                status[s] = ST_FREE;
            end
            else if (m == MODE_BIND)
            begin
                chan[s] = ch;
                word[s] = pl;
                bound[s] = 1;
            end
            else if (m == MODE_ARM)
            begin
                if (status[s] == ST_RUN)
                    drop_slot(s);
                due[s] = now_count + dl;
                status[s] = ST_RUN;
                place_slot(s);
            end
            else if (m == MODE_CANCEL)
            begin
                if (status[s] == ST_RUN)
                begin
                    drop_slot(s);
                    status[s] = ST_ALLOC;
                    ok = 1;
                end
            end
            r.push_back(mk_rsp(KIND_ACK, ok, 5'd0, 8'd0, 32'd0, 1'b0));
        end
        r[r.size()-1].last = 1;
        posts += r.size();
        foreach (r[i])
            board.note_expected(r[i]);
    endfunction

    initial
    begin
        cmd.valid = 1'b0;
        cmd.mode = '0;
        cmd.slot = '0;
        cmd.channel = '0;
        cmd.payload = '0;
        cmd.delay = '0;
        rsp.ready = 1'b0;
    end

    // one command transfer, with a random gap first; prediction at acceptance
    task automatic send(logic [2:0] m, logic [4:0] s, logic [7:0] ch,
                        logic [31:0] pl, logic [31:0] dl, bit gaps);
        int g;
        g = gaps ? $urandom_range(0, 11) : 0;
        // keep some stretches without idling
        if (gaps && $urandom_range(0, 3) == 0)
            g = 0;
        if (g > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.mode <= m;
        cmd.slot <= s;
        cmd.channel <= ch;
        cmd.payload <= pl;
        cmd.delay <= dl;
        do
            @(posedge clk);
        while (!cmd.ready);
        predict(m, s, ch, pl, dl);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        // then idle on past the last result before the next phase
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TASK_SLOT)
            task_no = v[4:0];
        else if (idx == REG_TASK_ENABLE)
            task_on = v[0];
        else
            slow = v;
        @(posedge clk);
    endtask

    // random slot, drawn uniformly from all slots
    function automatic logic [4:0] pick_slot();
        int s;
        s = $urandom_range(0, NSLOT - 1);
        return s[4:0];
    endfunction

    task automatic random_phase(int count, logic [31:0] dl_max);
        int          sel;
        logic [4:0]  s;
        logic [31:0] dl;
        for (int k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 99);
            s = pick_slot();
            dl = $urandom_range(0, dl_max);
            if ($urandom_range(0, 19) == 0)
                dl = $urandom();
            if (sel < 8)
                send(MODE_ALLOC, s, 8'($urandom()), $urandom(), $urandom(), 1);
            else if (sel < 14)
                send(MODE_FREE, s, 8'($urandom()), $urandom(), $urandom(), 1);
            else if (sel < 24)
                send(MODE_BIND, s, 8'($urandom()), $urandom(), $urandom(), 1);
            else if (sel < 48)
            begin
                // arm only bound slots: an unbound expiry is never caused
                if (bound[s])
                    send(MODE_ARM, s, 8'($urandom()), $urandom(), dl, 1);
                else
                    send(MODE_BIND, s, 8'($urandom()), $urandom(), $urandom(), 1);
            end
            else if (sel < 56)
                send(MODE_CANCEL, s, 8'($urandom()), $urandom(), $urandom(), 1);
            else if (sel < 58)
                send(3'($urandom_range(6, 7)), s, 8'($urandom()), $urandom(), $urandom(), 1);
            else
                send(MODE_TICK, s, 8'($urandom()), $urandom(), $urandom(), 1);
        end
    endtask

    // result side: each transfer draws a random wait, counted down in rsp_gap, before ready rises again
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                board.check_result(mk_rsp(rsp.kind, rsp.ok, rsp.slot_out,
                                          rsp.channel_out, rsp.payload_out, rsp.last));
                rsp_gap = $urandom_range(0, 11);
            end
            else if (rsp_gap > 0)
                rsp_gap--;
            rsp.ready <= (rsp_gap == 0);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("[timer_pool_deadline_queue_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < NSLOT; i++)
        begin
            status[i] = ST_FREE;
            bound[i] = 0;
            chan[i] = '0;
            word[i] = '0;
            due[i] = '0;
        end
        now_count = '0;
        pre_count = '0;
        task_no = '0;
        task_on = 1'b0;
        slow = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: registers at extremes, every mode, special cases
        write_reg(REG_TASK_SLOT, 8'd31);
        write_reg(REG_TASK_ENABLE, 8'd1);
        write_reg(REG_SLOWDOWN, 8'd0);
        send(MODE_ALLOC, 0, 0, 0, 0, 0);
        send(MODE_BIND, 0, 8'hff, 32'hffff_ffff, 0, 0);
        send(MODE_BIND, 31, 8'h00, 32'h0, 0, 0);
        send(MODE_BIND, 5, 8'ha5, 32'h5a5a_a5a5, 0, 0);
        send(MODE_ARM, 0, 0, 0, 32'd2, 0);
        send(MODE_ARM, 5, 0, 0, 32'd2, 0);         // equal deadline, sits first
        send(MODE_ARM, 31, 0, 0, 32'd1, 0);        // task slot
        send(MODE_ARM, 31, 0, 0, 32'd1, 0);        // re-arm running timer
        send(MODE_TICK, 0, 0, 0, 0, 0);
        send(MODE_TICK, 0, 0, 0, 0, 0);
        send(MODE_CANCEL, 5, 0, 0, 0, 0);          // not running
        send(MODE_ARM, 5, 0, 0, 32'hffff_ffff, 0); // far deadline
        send(MODE_CANCEL, 5, 0, 0, 0, 0);
        send(MODE_ARM, 0, 0, 0, 32'd7, 0);
        send(MODE_FREE, 0, 0, 0, 0, 0);            // free a running timer
        send(3'd6, 0, 0, 0, 0, 0);
        send(3'd7, 31, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 0);
        send(MODE_TICK, 0, 0, 0, 0, 0);            // quiet tick
        repeat (33) send(MODE_ALLOC, 0, 0, 0, 0, 0); // pool runs out
        // many expiries: arm all slots with equal deadline
        for (int i = 0; i < NSLOT; i++)
            send(MODE_BIND, 5'(i), 8'($urandom()), $urandom(), 0, 0);
        for (int i = 0; i < NSLOT; i++)
            send(MODE_ARM, 5'(i), 0, 0, 32'd1, 0);
        send(MODE_TICK, 0, 0, 0, 0, 0);
        drain(); // sender holds off until all results are in

        write_reg(REG_SLOWDOWN, 8'd3);
        write_reg(REG_TASK_ENABLE, 8'd0);
        random_phase(130, 12);
        drain();
        write_reg(REG_SLOWDOWN, 8'd255);
        write_reg(REG_TASK_SLOT, 8'd7);
        write_reg(REG_TASK_ENABLE, 8'd1);
        random_phase(20, 3);
        drain();
        write_reg(REG_SLOWDOWN, 8'd0);
        write_reg(REG_TASK_SLOT, 8'd0);
        random_phase(134, 20);

        drain();
        repeat (20) @(posedge clk);
        $display("Covered all modes, %0d results, %0d counted ticks, three register settings.",
                 posts, ticks_counted);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("[timer_pool_deadline_queue_unit] OK");
        else
            $display("[timer_pool_deadline_queue_unit] ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
src/tpdq_pkg.sv
src/tpdq_if.sv
src/tpdq_cell.sv
src/timer_pool_deadline_queue_unit.sv
test/tpdq_tb_if.sv
test/timer_pool_deadline_queue_unit_tb.sv
